// File: rtl/set_assoc_lru_cache_model_unit_defines.svh
// Assertion macros shared by the cache model checker.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SACL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SACL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sacl_pkg.sv
// Shared types, codes and fixed widths of the set-associative LRU cache model.
package sacl_pkg;

  localparam int ACTION_W     = 2;
  localparam int ADDR_W       = 32;
  localparam int CNT_W        = 32;
  localparam int OUTCOME_W    = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int SET_BITS_W   = 3;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 5;
  localparam int SHIFT_W      = 6;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_FETCH  = 2'd3
  } action_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT     = 2'd0,
    OUT_MISS    = 2'd1,
    OUT_EVICT   = 2'd2,
    OUT_IGNORED = 2'd3
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS       = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  typedef struct packed {
    logic     hit;
    logic     evict;
    outcome_t outcome;
  } acc_res_t;

endpackage

// File: rtl/set_assoc_lru_cache_model_unit.sv
// Set-associative LRU cache tag model: takes a new trace request only after the
// previous one has been looked up. Each request first reads its set row from the
// set memory, then looks up, updates the LRU ranks and writes the row back; the result
// then sits in the output register while the next request is taken. A stalled result
// holds the update until the output frees. A modify costs the same as a load,
// since its second access is a known hit. Configuration writes clear all sets at
// once through one valid bit per set, with no clearing pass after reset.
module set_assoc_lru_cache_model_unit #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sacl_pkg::ACTION_W-1:0]      in_action,
  input  logic [sacl_pkg::ADDR_W-1:0]        in_address,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sacl_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic                               out_second_hit,
  output logic [sacl_pkg::CNT_W-1:0]         out_hit_total,
  output logic [sacl_pkg::CNT_W-1:0]         out_miss_total,
  output logic [sacl_pkg::CNT_W-1:0]         out_evict_total,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int TAG_W  = (ADDR_BITS < sacl_pkg::ADDR_W) ? ADDR_BITS : sacl_pkg::ADDR_W;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W = 1 + RANK_W + TAG_W;
  localparam int ROW_W  = MAX_WAYS * LINE_W;
  localparam int NW_W   = $clog2(MAX_WAYS + 1);

  sacl_pkg::state_t state_r, state_nxt;

  logic [sacl_pkg::SET_BITS_W-1:0]   set_bits_r;
  logic [sacl_pkg::WAYS_W-1:0]       ways_r;
  logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits_r;

  logic [SETS-1:0]   set_ok_r;
  logic [TAG_W-1:0]  tag_r;
  logic [SET_W-1:0]  set_r;
  logic [sacl_pkg::ACTION_W-1:0] act_r;

  logic [sacl_pkg::CNT_W-1:0] hit_r, hit_nxt;
  logic [sacl_pkg::CNT_W-1:0] miss_r, miss_nxt;
  logic [sacl_pkg::CNT_W-1:0] evict_r, evict_nxt;

  logic                           out_valid_r;
  logic [sacl_pkg::OUTCOME_W-1:0] outcome_r, outcome_nxt;
  logic                           second_r;

  logic [sacl_pkg::SET_BITS_W-1:0] sb_eff;
  logic [sacl_pkg::SHIFT_W-1:0]    shift;
  logic [NW_W-1:0]                 nw;
  logic [TAG_W-1:0]                addr_eff;
  logic [TAG_W-1:0]                set_raw;
  logic [SET_W-1:0]                set_mask;
  logic [SET_W-1:0]                set_in;
  logic [TAG_W-1:0]                tag_in;

  logic accept;
  logic look;
  logic fire;
  logic is_fetch;
  logic is_mod;
  logic do_write;
  logic cfg_hit;

  logic [ROW_W-1:0]   row_rd;
  logic [ROW_W-1:0]   row_wr;
  sacl_pkg::acc_res_t res;

  assign sb_eff   = (32'(set_bits_r) > MAX_SET_BITS) ?
                    sacl_pkg::SET_BITS_W'(MAX_SET_BITS) : set_bits_r;
  assign shift    = sacl_pkg::SHIFT_W'(sb_eff) + sacl_pkg::SHIFT_W'(block_bits_r);
  assign addr_eff = in_address[TAG_W-1:0];
  assign tag_in   = addr_eff >> shift;
  assign set_raw  = addr_eff >> block_bits_r;
  assign set_mask = ~({SET_W{1'b1}} << sb_eff);
  assign set_in   = set_raw[SET_W-1:0] & set_mask;

  always_comb begin
    priority if (ways_r == '0) begin
      nw = NW_W'(1);
    end else if (32'(ways_r) > MAX_WAYS) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = NW_W'(ways_r);
    end
  end

  assign in_ready  = (state_r == sacl_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign look      = (state_r == sacl_pkg::ST_LOOK);
  assign fire      = look && (!out_valid_r || out_ready);
  assign is_fetch  = (act_r == sacl_pkg::ACT_FETCH);
  assign is_mod    = (act_r == sacl_pkg::ACT_MODIFY);
  assign do_write  = fire && !is_fetch;
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (set_r),
    .wdata (row_wr),
    .re    (accept),
    .raddr (set_in),
    .rdata (row_rd)
  );

  sacl_set_upd #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W)
  ) u_set_upd (
    .row_ok  (set_ok_r[set_r]),
    .row_in  (row_rd),
    .tag     (tag_r),
    .nw      (nw),
    .row_out (row_wr),
    .res     (res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sacl_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = sacl_pkg::ST_LOOK;
        end
      end
      sacl_pkg::ST_LOOK: begin
        if (fire) begin
          state_nxt = sacl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sacl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    hit_nxt     = hit_r;
    miss_nxt    = miss_r;
    evict_nxt   = evict_r;
    outcome_nxt = sacl_pkg::OUT_IGNORED;
    if (!is_fetch) begin
      hit_nxt     = hit_r + sacl_pkg::CNT_W'(res.hit) + sacl_pkg::CNT_W'(is_mod);
      miss_nxt    = miss_r + sacl_pkg::CNT_W'(!res.hit);
      evict_nxt   = evict_r + sacl_pkg::CNT_W'(res.evict);
      outcome_nxt = res.outcome;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sacl_pkg::ST_IDLE;
      set_bits_r   <= sacl_pkg::SET_BITS_RST;
      ways_r       <= sacl_pkg::WAYS_RST;
      block_bits_r <= sacl_pkg::BLOCK_BITS_RST;
      set_ok_r     <= '0;
      hit_r        <= '0;
      miss_r       <= '0;
      evict_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_hit) begin
        unique case (cfg_index)
          sacl_pkg::CFG_SET_BITS: begin
            set_bits_r <= cfg_data[sacl_pkg::SET_BITS_W-1:0];
            set_ok_r   <= '0;
          end
          sacl_pkg::CFG_WAYS: begin
            ways_r   <= cfg_data[sacl_pkg::WAYS_W-1:0];
            set_ok_r <= '0;
          end
          sacl_pkg::CFG_BLOCK_BITS: begin
            block_bits_r <= cfg_data;
            set_ok_r     <= '0;
          end
          default: begin
          end
        endcase
      end else if (do_write) begin
        set_ok_r[set_r] <= 1'b1;
      end
      if (fire) begin
        hit_r       <= hit_nxt;
        miss_r      <= miss_nxt;
        evict_r     <= evict_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r <= tag_in;
      set_r <= set_in;
      act_r <= in_action;
    end
    if (fire) begin
      outcome_r <= outcome_nxt;
      second_r  <= is_mod;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_outcome     = outcome_r;
  assign out_second_hit  = second_r;
  assign out_hit_total   = hit_r;
  assign out_miss_total  = miss_r;
  assign out_evict_total = evict_r;

endmodule

// File: rtl/sacl_ram.sv
// Generic single-port-write, registered-read RAM.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sacl_set_upd.sv
// Set lookup and LRU update: hit search, fill or victim choice, rank rewrite.
module sacl_set_upd #(
  parameter int MAX_WAYS = 8,
  parameter int TAG_W    = 32,
  localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int LINE_W  = 1 + RANK_W + TAG_W,
  localparam int ROW_W   = MAX_WAYS * LINE_W,
  localparam int NW_W    = $clog2(MAX_WAYS + 1)
) (
  input  logic                 row_ok,
  input  logic [ROW_W-1:0]     row_in,
  input  logic [TAG_W-1:0]     tag,
  input  logic [NW_W-1:0]      nw,
  output logic [ROW_W-1:0]     row_out,
  output sacl_pkg::acc_res_t   res
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0] use_w;
  logic [MAX_WAYS-1:0] vld;
  logic [MAX_WAYS-1:0] hit_w;
  logic [MAX_WAYS-1:0] emp_w;
  logic [RANK_W-1:0]   rank_w [MAX_WAYS];
  logic [TAG_W-1:0]    tag_w  [MAX_WAYS];

  logic              hit_any;
  logic              emp_any;
  logic [WAY_W-1:0]  hit_idx;
  logic [WAY_W-1:0]  emp_idx;
  logic [WAY_W-1:0]  vic_idx;
  logic [RANK_W-1:0] vic_rank;
  logic [WAY_W-1:0]  sel;
  logic              sel_valid;
  logic [RANK_W-1:0] sel_rank;

  for (genvar g = 0; g < MAX_WAYS; g++) begin : g_lane
    assign use_w[g]  = 32'(g) < 32'(nw);
    assign vld[g]    = row_ok & use_w[g] & row_in[g*LINE_W + LINE_W - 1];
    assign rank_w[g] = row_ok ? row_in[g*LINE_W + TAG_W +: RANK_W] : '0;
    assign tag_w[g]  = row_in[g*LINE_W +: TAG_W];
    assign hit_w[g]  = vld[g] && (tag_w[g] == tag);
    assign emp_w[g]  = use_w[g] && !vld[g];
  end

  always_comb begin
    hit_any  = |hit_w;
    emp_any  = |emp_w;
    hit_idx  = '0;
    emp_idx  = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_w[i]) begin
        hit_idx = WAY_W'(i);
      end
      if (emp_w[i]) begin
        emp_idx = WAY_W'(i);
      end
    end
    vic_idx  = '0;
    vic_rank = rank_w[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (use_w[i] && (rank_w[i] > vic_rank)) begin
        vic_idx  = WAY_W'(i);
        vic_rank = rank_w[i];
      end
    end
    priority if (hit_any) begin
      sel = hit_idx;
    end else if (emp_any) begin
      sel = emp_idx;
    end else begin
      sel = vic_idx;
    end
  end

  assign sel_valid = vld[sel];
  assign sel_rank  = rank_w[sel];

  for (genvar g = 0; g < MAX_WAYS; g++) begin : g_new
    logic              is_sel;
    logic              bump;
    logic [RANK_W-1:0] rank_nxt;
    logic [TAG_W-1:0]  tag_nxt;

    assign is_sel   = (sel == WAY_W'(g));
    assign bump     = vld[g] && !is_sel && (!sel_valid || (rank_w[g] < sel_rank));
    assign rank_nxt = is_sel ? '0 :
                      (bump && (rank_w[g] != RANK_MAX)) ? rank_w[g] + 1'b1 : rank_w[g];
    assign tag_nxt  = (is_sel && !hit_any) ? tag : tag_w[g];
    assign row_out[g*LINE_W +: LINE_W] = {vld[g] | is_sel, rank_nxt, tag_nxt};
  end

  always_comb begin
    res.hit   = hit_any;
    res.evict = !hit_any && !emp_any;
    priority if (hit_any) begin
      res.outcome = sacl_pkg::OUT_HIT;
    end else if (emp_any) begin
      res.outcome = sacl_pkg::OUT_MISS;
    end else begin
      res.outcome = sacl_pkg::OUT_EVICT;
    end
  end

endmodule

// File: rtl/sacl_checker.sv
// Port-level checker for the cache model, bound to the top level.
`include "set_assoc_lru_cache_model_unit_defines.svh"

module sacl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sacl_pkg::OUTCOME_W-1:0]  out_outcome,
  input logic [sacl_pkg::CNT_W-1:0]      out_hit_total,
  input logic [sacl_pkg::CNT_W-1:0]      out_miss_total,
  input logic [sacl_pkg::CNT_W-1:0]      out_evict_total
);

  logic [sacl_pkg::CNT_W-1:0] last_hit_r;
  logic [sacl_pkg::CNT_W-1:0] last_miss_r;
  logic [sacl_pkg::CNT_W-1:0] last_evict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_hit_r   <= '0;
      last_miss_r  <= '0;
      last_evict_r <= '0;
    end else if (out_valid && out_ready) begin
      last_hit_r   <= out_hit_total;
      last_miss_r  <= out_miss_total;
      last_evict_r <= out_evict_total;
    end
  end

  `SACL_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_outcome) && $stable(out_hit_total), "stalled result changed")
  `SACL_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready,
    !in_ready, "request taken while previous one still in lookup")
  `SACL_ASSERT_IMP(a_ignored_keeps_totals, out_valid && (out_outcome == sacl_pkg::OUT_IGNORED),
    (out_hit_total == last_hit_r) && (out_miss_total == last_miss_r) &&
    (out_evict_total == last_evict_r), "ignored request moved a total")
  `SACL_ASSERT_IMP(a_evict_counts, out_valid && (out_outcome == sacl_pkg::OUT_EVICT),
    out_evict_total != last_evict_r, "eviction not counted")

endmodule

bind set_assoc_lru_cache_model_unit sacl_checker u_sacl_checker (.*);

// File: dv/set_assoc_lru_cache_model_unit_checker.sv
// Checker for the cache model: predicts the result of each accepted request and compares.
module set_assoc_lru_cache_model_unit_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [sacl_pkg::ACTION_W-1:0]   in_action,
  input  logic [sacl_pkg::ADDR_W-1:0]     in_address,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [sacl_pkg::OUTCOME_W-1:0]  out_outcome,
  input  logic                            out_second_hit,
  input  logic [sacl_pkg::CNT_W-1:0]      out_hit_total,
  input  logic [sacl_pkg::CNT_W-1:0]      out_miss_total,
  input  logic [sacl_pkg::CNT_W-1:0]      out_evict_total,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              outstanding,
  output int                              fail_count
);
  import sacl_pkg::*;

  localparam int SET_CAP    = 6;
  localparam int WAY_CAP    = 8;
  localparam int LINE_CNT   = (1 << SET_CAP) * WAY_CAP;
  localparam logic [2:0] AGE_TOP = 3'(WAY_CAP - 1);
  localparam int REPORT_MAX = 10;

  typedef struct {
    outcome_t         outcome;
    logic             second_hit;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evicts;
  } cache_result_t;

  logic [SET_BITS_W-1:0]   set_bits_q;
  logic [WAYS_W-1:0]       ways_q;
  logic [BLOCK_BITS_W-1:0] block_bits_q;

  bit               line_live [LINE_CNT];
  logic [ADDR_W-1:0] line_key [LINE_CNT];
  logic [2:0]       line_age  [LINE_CNT];
  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] evict_cnt;

  cache_result_t owed_results [$];
  cache_result_t head;
  int            errs;

  function automatic void flush_lines();
    for (int i = 0; i < LINE_CNT; i++) begin
      line_live[i] = 1'b0;
      line_age[i]  = '0;
    end
  endfunction

  function automatic int unsigned ways_in_use();
    if (ways_q == 0) return 1;
    if (ways_q > WAY_CAP) return WAY_CAP;
    return ways_q;
  endfunction

  function automatic void make_recent(int unsigned base, int unsigned nw, int unsigned w);
    bit         was_live;
    logic [2:0] r;
    was_live = line_live[base + w];
    r        = line_age[base + w];
    for (int unsigned a = 0; a < nw; a++) begin
      if (a != w && line_live[base + a] && (!was_live || line_age[base + a] < r) &&
          line_age[base + a] != AGE_TOP) begin
        line_age[base + a]++;
      end
    end
    line_age[base + w]  = '0;
    line_live[base + w] = 1'b1;
  endfunction

  function automatic outcome_t access_set(int unsigned set_idx, logic [ADDR_W-1:0] key);
    int unsigned nw;
    int unsigned base;
    int unsigned victim;
    bit          found;
    nw   = ways_in_use();
    base = set_idx * WAY_CAP;
    for (int unsigned w = 0; w < nw; w++) begin
      if (line_live[base + w] && line_key[base + w] == key) begin
        make_recent(base, nw, w);
        hit_cnt++;
        return OUT_HIT;
      end
    end
    miss_cnt++;
    found  = 1'b0;
    victim = 0;
    for (int unsigned w = 0; w < nw; w++) begin
      if (!found && !line_live[base + w]) begin
        victim = w;
        found  = 1'b1;
      end
    end
    if (!found) begin
      evict_cnt++;
      for (int unsigned w = 1; w < nw; w++) begin
        if (line_age[base + w] > line_age[base + victim]) victim = w;
      end
    end
    make_recent(base, nw, victim);
    line_key[base + victim] = key;
    return found ? OUT_MISS : OUT_EVICT;
  endfunction

  function automatic cache_result_t predict_access(logic [ACTION_W-1:0] act,
                                                   logic [ADDR_W-1:0] addr);
    cache_result_t r;
    int unsigned   sb;
    int unsigned   shift;
    int unsigned   set_idx;
    logic [63:0]   wide;
    logic [ADDR_W-1:0] key;
    sb      = (set_bits_q > SET_CAP) ? SET_CAP : set_bits_q;
    shift   = sb + block_bits_q;
    wide    = {32'd0, addr};
    key     = ADDR_W'(wide >> shift);
    set_idx = int'((wide >> block_bits_q) & ((64'd1 << sb) - 64'd1));
    r.outcome    = OUT_IGNORED;
    r.second_hit = 1'b0;
    if (act != ACT_FETCH) begin
      r.outcome = access_set(set_idx, key);
      if (act == ACT_MODIFY) r.second_hit = (access_set(set_idx, key) == OUT_HIT);
    end
    r.hits   = hit_cnt;
    r.misses = miss_cnt;
    r.evicts = evict_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      set_bits_q   = SET_BITS_RST;
      ways_q       = WAYS_RST;
      block_bits_q = BLOCK_BITS_RST;
      flush_lines();
      hit_cnt   = '0;
      miss_cnt  = '0;
      evict_cnt = '0;
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS: begin
            set_bits_q = cfg_data[SET_BITS_W-1:0];
            flush_lines();
          end
          CFG_WAYS: begin
            ways_q = cfg_data[WAYS_W-1:0];
            flush_lines();
          end
          CFG_BLOCK_BITS: begin
            block_bits_q = cfg_data[BLOCK_BITS_W-1:0];
            flush_lines();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) owed_results.push_back(predict_access(in_action, in_address));
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          errs++;
          if (errs <= REPORT_MAX)
            $display("result with no request pending: outcome=%0d second_hit=%0d",
                     out_outcome, out_second_hit);
        end else begin
          head = owed_results.pop_front();
          if (out_outcome !== head.outcome || out_second_hit !== head.second_hit ||
              out_hit_total !== head.hits || out_miss_total !== head.misses ||
              out_evict_total !== head.evicts) begin
            errs++;
            if (errs <= REPORT_MAX) begin
              $display("mismatch: expected outcome=%0d second_hit=%0d hits=%0d misses=%0d evicts=%0d",
                       head.outcome, head.second_hit, head.hits, head.misses, head.evicts);
              $display("          actual   outcome=%0d second_hit=%0d hits=%0d misses=%0d evicts=%0d",
                       out_outcome, out_second_hit, out_hit_total, out_miss_total,
                       out_evict_total);
            end
          end
        end
      end
    end
    outstanding <= owed_results.size();
    fail_count  <= errs;
  end

endmodule

// File: dv/tb_set_assoc_lru_cache_model_unit.sv
// Testbench top for the cache model: reset, directed and random trace requests, verdict.
module tb_set_assoc_lru_cache_model_unit;
  import sacl_pkg::*;

  localparam int RUN_LIMIT      = 200000;
  localparam int RAND_PER_PHASE = 140;
  localparam int SETTLE         = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAY = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [ACTION_W-1:0]   in_action;
  logic [ADDR_W-1:0]     in_address;
  logic                  out_valid;
  logic                  out_ready;
  logic [OUTCOME_W-1:0]  out_outcome;
  logic                  out_second_hit;
  logic [CNT_W-1:0]      out_hit_total;
  logic [CNT_W-1:0]      out_miss_total;
  logic [CNT_W-1:0]      out_evict_total;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          outstanding;
  int          fail_count;
  int          cycle_cnt;
  bit          steady;
  int unsigned cur_sb;
  int unsigned cur_ways;
  int unsigned cur_bb;
  logic [31:0] tag_base;

  int unsigned ph_sb    [7] = '{7, 6, 0, 2, 3, 1, 5};
  int unsigned ph_ways  [7] = '{0, 8, 15, 2, 4, 9, 3};
  int unsigned ph_bb    [7] = '{31, 26, 27, 5, 0, 12, 8};
  bit          ph_stray [7] = '{0, 0, 1, 0, 0, 1, 0};

  set_assoc_lru_cache_model_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_outcome    (out_outcome),
    .out_second_hit (out_second_hit),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total),
    .out_evict_total(out_evict_total),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  set_assoc_lru_cache_model_unit_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_outcome    (out_outcome),
    .out_second_hit (out_second_hit),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total),
    .out_evict_total(out_evict_total),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outstanding    (outstanding),
    .fail_count     (fail_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_req(input action_t act, input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic cfg_push(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_cfg(input int unsigned sb, input int unsigned w, input int unsigned bb,
                           input bit stray);
    drain();
    cfg_push(CFG_SET_BITS, sb);
    cfg_push(CFG_WAYS, w);
    cfg_push(CFG_BLOCK_BITS, bb);
    if (stray) cfg_push(CFG_STRAY, $urandom_range(0, 31));
    cfg_valid <= 1'b0;
    cur_sb   = sb;
    cur_ways = w;
    cur_bb   = bb;
    tag_base = $urandom();
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [63:0] a;
    int unsigned sbe;
    int unsigned set_pick;
    logic [31:0] key;
    if ($urandom_range(0, 9) < 2) return $urandom();
    sbe      = (cur_sb > 6) ? 6 : cur_sb;
    set_pick = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3);
    key      = tag_base + $urandom_range(0, 10);
    a = 64'($urandom()) & ((64'd1 << cur_bb) - 64'd1);
    a = a | ((64'(set_pick) & ((64'd1 << sbe) - 64'd1)) << cur_bb);
    a = a | (64'(key) << (sbe + cur_bb));
    return a[ADDR_W-1:0];
  endfunction

  task automatic run_random(input int unsigned n);
    int unsigned done;
    int unsigned r;
    action_t     act;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 39) == 0) steady = ($urandom_range(0, 2) == 0);
      r   = $urandom_range(0, 9);
      act = (r < 3) ? ACT_LOAD : (r < 6) ? ACT_STORE : (r < 9) ? ACT_MODIFY : ACT_FETCH;
      send_req(act, pick_addr());
      done++;
    end
  endtask

  initial begin
    int unsigned gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_action  <= ACT_LOAD;
    in_address <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_SET_BITS;
    cfg_data   <= '0;
    steady   = 1'b0;
    cur_sb   = SET_BITS_RST;
    cur_ways = WAYS_RST;
    cur_bb   = BLOCK_BITS_RST;
    tag_base = $urandom();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: one way, hit, fill, evict, ignored fetch, modify
    send_req(ACT_LOAD,   32'h0000_0000);
    send_req(ACT_LOAD,   32'h0000_000F);
    send_req(ACT_STORE,  32'h0000_0010);
    send_req(ACT_MODIFY, 32'h0000_0100);
    send_req(ACT_FETCH,  32'hFFFF_FFFF);
    send_req(ACT_LOAD,   32'hFFFF_FFFF);
    send_req(ACT_STORE,  32'hFFFF_FFF0);
    send_req(ACT_MODIFY, 32'hFFFF_FFFF);
    send_req(ACT_LOAD,   32'h0000_00F0);
    send_req(ACT_FETCH,  32'h0000_0000);
    send_req(ACT_MODIFY, 32'h0000_0010);

    // one fully associative set: fill all ways, then walk the LRU order
    apply_cfg(0, 8, 0, 1'b0);
    for (int unsigned i = 0; i < 8; i++) send_req(ACT_LOAD, ADDR_W'(i));
    send_req(ACT_LOAD,   32'h0000_0000);
    send_req(ACT_LOAD,   32'h0000_0008);
    send_req(ACT_LOAD,   32'h0000_0001);
    send_req(ACT_STORE,  32'h8000_0000);
    send_req(ACT_LOAD,   32'hFFFF_FFFF);
    send_req(ACT_MODIFY, 32'h0000_0000);

    apply_cfg(SET_BITS_RST, WAYS_RST, BLOCK_BITS_RST, 1'b0);
    run_random(RAND_PER_PHASE);
    for (int p = 0; p < 7; p++) begin
      apply_cfg(ph_sb[p], ph_ways[p], ph_bb[p], ph_stray[p]);
      run_random(RAND_PER_PHASE);
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_ram.sv
rtl/sacl_set_upd.sv
rtl/set_assoc_lru_cache_model_unit.sv
rtl/sacl_checker.sv
dv/set_assoc_lru_cache_model_unit_checker.sv
dv/tb_set_assoc_lru_cache_model_unit.sv
